/* hdl/dsi_pkg.sv */
// shared types and constants for the decimal string to int32 converter
// no dependencies; used by the front end, the queue, the back end and the top level
`timescale 1ns / 1ps

package dsi_pkg;

    // character classes made by the front end
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_SIGN_POS,
        CLS_SIGN_NEG,
        CLS_DIGIT,
        CLS_BREAK,
        CLS_OTHER
    } cls_t;

    // parse phases of the back end
    typedef enum logic [2:0] {
        PH_SPACES,
        PH_SIGN,
        PH_DIGITS,
        PH_TAIL,
        PH_FAIL
    } phase_t;

    // one classified character as it sits in the queue
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       last;
    } qent_t;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
    } qstat_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [31:0] SAT_THRESH  = 32'd214748364;
    localparam logic [3:0]  LAST_POS    = 4'd7;
    localparam logic [3:0]  LAST_NEG    = 4'd8;
    localparam logic [31:0] MAG_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAG_MAX_NEG = 32'h8000_0000;

endpackage

/* hdl/dsi_queue.sv */
// short queue of classified characters between front and back end
// depends on dsi_pkg
`timescale 1ns / 1ps

module dsi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dsi_pkg::qent_t push_ent,
    output dsi_pkg::qstat_t stat,
    input  logic          pop,
    output dsi_pkg::qent_t pop_ent,
    output logic          nonempty
);

    dsi_pkg::qent_t                    slot_reg [dsi_pkg::QDEPTH];
    logic [dsi_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [dsi_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [dsi_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [dsi_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [dsi_pkg::QCNT_W-1:0]        count_reg;
    logic [dsi_pkg::QCNT_W-1:0]        count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ent;
        end
    end

    assign pop_ent   = slot_reg[rd_ptr_reg];
    assign nonempty  = (count_reg != '0);
    assign stat.full = (count_reg == dsi_pkg::QCNT_W'(dsi_pkg::QDEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dsi_pkg::QCNT_W'(dsi_pkg::QDEPTH))
        else $error("queue count past depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

/* hdl/dsi_front.sv */
// front end: takes character beats, classifies them and pushes them into the queue
// depends on dsi_pkg
`timescale 1ns / 1ps

module dsi_front (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      char_byte,
    input  logic            last_char,
    input  dsi_pkg::qstat_t stat,
    output logic            push,
    output dsi_pkg::qent_t  push_ent
);

    logic       is_digit;
    logic [3:0] digit_off;

    assign is_digit  = (char_byte >= dsi_pkg::CHAR_ZERO) && (char_byte <= dsi_pkg::CHAR_NINE);
    assign digit_off = 4'(char_byte - dsi_pkg::CHAR_ZERO);

    always_comb
    begin
        if (is_digit)
        begin
            push_ent.cls = dsi_pkg::CLS_DIGIT;
        end
        else if (char_byte == dsi_pkg::CHAR_SPACE)
        begin
            push_ent.cls = dsi_pkg::CLS_SPACE;
        end
        else if (char_byte == dsi_pkg::CHAR_PLUS)
        begin
            push_ent.cls = dsi_pkg::CLS_SIGN_POS;
        end
        else if (char_byte == dsi_pkg::CHAR_MINUS)
        begin
            push_ent.cls = dsi_pkg::CLS_SIGN_NEG;
        end
        else if ((char_byte == dsi_pkg::CHAR_LF) || (char_byte == dsi_pkg::CHAR_CR))
        begin
            push_ent.cls = dsi_pkg::CLS_BREAK;
        end
        else
        begin
            push_ent.cls = dsi_pkg::CLS_OTHER;
        end
        push_ent.digit = digit_off;
        push_ent.last  = last_char;
    end

    assign in_stall = stat.full;
    assign push     = in_valid && !stat.full;

endmodule

/* hdl/dsi_back.sv */
// back end: parse state machine, saturating accumulator and result register
// depends on dsi_pkg
`timescale 1ns / 1ps

module dsi_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                nonempty,
    input  dsi_pkg::qent_t      ent,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  value
);

    dsi_pkg::phase_t phase_reg;
    dsi_pkg::phase_t phase_step;
    dsi_pkg::phase_t phase_next;
    logic            neg_reg;
    logic            neg_step;
    logic            neg_next;
    logic [31:0]     acc_reg;
    logic [31:0]     acc_step;
    logic [31:0]     acc_next;
    logic            sat_reg;
    logic            sat_step;
    logic            sat_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     value_reg;
    logic [31:0]     result;

    logic            digit_en;
    logic            sign_en;
    logic            match;
    logic [31:0]     acc_x10;
    logic [31:0]     acc_sum;
    logic [3:0]      last_limit;
    logic            over;

    // pop when the entry needs no output slot or the slot frees this cycle
    assign pop = nonempty && (!ent.last || !out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        phase_step = phase_reg;
        unique case (phase_reg)
            dsi_pkg::PH_SPACES:
            begin
                unique case (ent.cls) inside
                    dsi_pkg::CLS_SPACE:                        phase_step = dsi_pkg::PH_SPACES;
                    dsi_pkg::CLS_SIGN_POS, dsi_pkg::CLS_SIGN_NEG: phase_step = dsi_pkg::PH_SIGN;
                    dsi_pkg::CLS_DIGIT:                        phase_step = dsi_pkg::PH_DIGITS;
                    default:                                   phase_step = dsi_pkg::PH_FAIL;
                endcase
            end
            dsi_pkg::PH_SIGN:
            begin
                phase_step = (ent.cls == dsi_pkg::CLS_DIGIT) ? dsi_pkg::PH_DIGITS
                                                             : dsi_pkg::PH_FAIL;
            end
            dsi_pkg::PH_DIGITS:
            begin
                unique case (ent.cls) inside
                    dsi_pkg::CLS_DIGIT: phase_step = dsi_pkg::PH_DIGITS;
                    dsi_pkg::CLS_BREAK: phase_step = dsi_pkg::PH_FAIL;
                    default:            phase_step = dsi_pkg::PH_TAIL;
                endcase
            end
            dsi_pkg::PH_TAIL:
            begin
                phase_step = (ent.cls == dsi_pkg::CLS_BREAK) ? dsi_pkg::PH_FAIL
                                                             : dsi_pkg::PH_TAIL;
            end
            default:
            begin
                phase_step = dsi_pkg::PH_FAIL;
            end
        endcase

        if (!pop)
        begin
            phase_next = phase_reg;
        end
        else if (ent.last)
        begin
            phase_next = dsi_pkg::PH_SPACES;
        end
        else
        begin
            phase_next = phase_step;
        end
    end

    // state outputs
    always_comb
    begin
        digit_en = 1'b0;
        sign_en  = 1'b0;
        unique case (phase_reg) inside
            dsi_pkg::PH_SPACES:
            begin
                digit_en = (ent.cls == dsi_pkg::CLS_DIGIT);
                sign_en  = (ent.cls == dsi_pkg::CLS_SIGN_POS) ||
                           (ent.cls == dsi_pkg::CLS_SIGN_NEG);
            end
            dsi_pkg::PH_SIGN, dsi_pkg::PH_DIGITS:
            begin
                digit_en = (ent.cls == dsi_pkg::CLS_DIGIT);
            end
            default:
            begin
                digit_en = 1'b0;
            end
        endcase
        match = (phase_step == dsi_pkg::PH_DIGITS) || (phase_step == dsi_pkg::PH_TAIL);
    end

    // accumulate one digit with saturation
    always_comb
    begin
        acc_x10    = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
        acc_sum    = acc_x10 + {28'd0, ent.digit};
        last_limit = neg_reg ? dsi_pkg::LAST_NEG : dsi_pkg::LAST_POS;
        over       = (acc_reg > dsi_pkg::SAT_THRESH) ||
                     ((acc_reg == dsi_pkg::SAT_THRESH) && (ent.digit > last_limit));
        neg_step   = sign_en ? (ent.cls == dsi_pkg::CLS_SIGN_NEG) : neg_reg;
        acc_step   = acc_reg;
        sat_step   = sat_reg;
        if (digit_en && !sat_reg)
        begin
            if (over)
            begin
                acc_step = neg_reg ? dsi_pkg::MAG_MAX_NEG : dsi_pkg::MAG_MAX_POS;
                sat_step = 1'b1;
            end
            else
            begin
                acc_step = acc_sum;
            end
        end
        result = match ? (neg_step ? (32'd0 - acc_step) : acc_step) : 32'd0;

        if (!pop)
        begin
            neg_next = neg_reg;
            acc_next = acc_reg;
            sat_next = sat_reg;
        end
        else if (ent.last)
        begin
            neg_next = 1'b0;
            acc_next = '0;
            sat_next = 1'b0;
        end
        else
        begin
            neg_next = neg_step;
            acc_next = acc_step;
            sat_next = sat_step;
        end

        if (pop && ent.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dsi_pkg::PH_SPACES;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && ent.last)
        begin
            value_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

`ifndef SYNTHESIS
    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == (neg_reg ? dsi_pkg::MAG_MAX_NEG : dsi_pkg::MAG_MAX_POS)))
        else $error("saturated accumulator off its bound");

    // a negative magnitude may reach 2^31 exactly without saturating
    a_unsat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !sat_reg |-> (acc_reg <= dsi_pkg::MAG_MAX_NEG))
        else $error("accumulator past int32 range without saturation");

    a_idle_before_digits: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == dsi_pkg::PH_SPACES) || (phase_reg == dsi_pkg::PH_SIGN))
        |-> ((acc_reg == '0) && !sat_reg))
        else $error("accumulator busy before any digit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ent.last) |=> ((phase_reg == dsi_pkg::PH_SPACES) && (acc_reg == '0)
                               && !neg_reg && out_valid_reg))
        else $error("end of string did not clear parse state");
`endif

endmodule

/* hdl/decimal_string_to_int32_core.sv */
// top level of the streaming decimal string to int32 converter (saturating atoi)
// depends on dsi_pkg, dsi_front, dsi_queue and dsi_back
`timescale 1ns / 1ps

// One character arrives per input beat (char_byte, with last_char marking the end of a
// string); one 32-bit signed result beat leaves for each string, on its last character.
// Leading spaces (0x20 only) are skipped, one optional sign is taken, then decimal digits
// build the value, which saturates at the int32 bounds and then holds. The first non-digit
// ends the number and later characters are ignored, but a CR or LF anywhere after the
// digits, a sign with no digits, only spaces, or any other leading character gives 0.
// The block takes one character per clock cycle while its queue is not full; that rate is
// set by the back end, which applies one multiply-by-ten-and-add with its saturation check
// per cycle. The last character of a string is written into a queue slot, and its result
// is then registered in the result register before the beat is presented. The front end
// classifies characters into a four-entry queue, so input beats keep flowing while a
// finished result waits on out_stall; in_stall rises only once that queue is full.
// The parse state returns to its reset values after every string. There are no configuration
// registers.

module decimal_string_to_int32_core (
    input  logic               clk,
    input  logic               rst_n,
    // character channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_byte,
    input  logic               last_char,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value
);

    // classified character beats from front to back
    dsi_pkg::qent_t  push_ent;
    dsi_pkg::qent_t  pop_ent;
    dsi_pkg::qstat_t q_stat;
    logic            push;
    logic            pop;
    logic            q_nonempty;

    // front end: classify and push, stall only on a full queue
    dsi_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .last_char (last_char),
        .stat      (q_stat),
        .push      (push),
        .push_ent  (push_ent)
    );

    // decoupling queue
    dsi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .stat     (q_stat),
        .pop      (pop),
        .pop_ent  (pop_ent),
        .nonempty (q_nonempty)
    );

    // back end: parse, accumulate, hold the result beat
    dsi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (q_nonempty),
        .ent       (pop_ent),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

endmodule
